// ===== hdl/periodic_euclidean_distance_macros.svh =====
// Assertion macros shared by the distance pipeline modules.
// Needs a clock named clk and an active-high reset named rst in the including module.
`ifndef PERIODIC_EUCLIDEAN_DISTANCE_MACROS_SVH
`define PERIODIC_EUCLIDEAN_DISTANCE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ped_pkg.sv =====
// Package for the periodic Euclidean distance block: widths, register codes, config struct.
// No dependencies; every other file of the block but the assertion macro header uses it.
`default_nettype none

package ped_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int MAX_DIMS    = 4;
  localparam int FIELD_DIMS  = 4;
  localparam int LIM_DIMS    = (MAX_DIMS < FIELD_DIMS) ? MAX_DIMS : FIELD_DIMS;

  localparam int NUM_DIMS_W  = 3;
  localparam int BOX_W       = 16;

  // Coordinate difference and its shifted versions.
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int MAG_W  = ((COORD_WIDTH > BOX_W) ? COORD_WIDTH : BOX_W) + 1;
  localparam int SGN_W  = MAG_W + 1;

  // Squares, sum of squares and square root.
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + $clog2(FIELD_DIMS);
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;

  localparam int DIST_W = 18;
  localparam int CMP_W  = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam int FRONT_STAGES = 6;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [NUM_DIMS_W-1:0] NUM_DIMS_RST = NUM_DIMS_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_METRIC_MODE = CFG_IDX_W'(0),
    REG_NUM_DIMS    = CFG_IDX_W'(1),
    REG_BOX_LEN_0   = CFG_IDX_W'(2),
    REG_BOX_LEN_1   = CFG_IDX_W'(3),
    REG_BOX_LEN_2   = CFG_IDX_W'(4),
    REG_BOX_LEN_3   = CFG_IDX_W'(5)
  } reg_idx_t;

  typedef struct packed {
    logic                              metric_mode;
    logic [NUM_DIMS_W-1:0]             num_dims;
    logic [FIELD_DIMS-1:0][BOX_W-1:0]  box_len;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/ped_pts_if.sv =====
// Input channel carrying one pair of points per item.
// Depends on ped_pkg for the coordinate width.
`default_nettype none

interface ped_pts_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ped_pkg::COORD_WIDTH-1:0] first_x0;
  logic signed [ped_pkg::COORD_WIDTH-1:0] first_x1;
  logic signed [ped_pkg::COORD_WIDTH-1:0] first_x2;
  logic signed [ped_pkg::COORD_WIDTH-1:0] first_x3;
  logic signed [ped_pkg::COORD_WIDTH-1:0] second_x0;
  logic signed [ped_pkg::COORD_WIDTH-1:0] second_x1;
  logic signed [ped_pkg::COORD_WIDTH-1:0] second_x2;
  logic signed [ped_pkg::COORD_WIDTH-1:0] second_x3;

  modport source (
    output valid, first_x0, first_x1, first_x2, first_x3,
    output second_x0, second_x1, second_x2, second_x3,
    input  ready
  );
  modport sink (
    input  valid, first_x0, first_x1, first_x2, first_x3,
    input  second_x0, second_x1, second_x2, second_x3,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/ped_dist_if.sv =====
// Output channel carrying one distance per item.
// Depends on ped_pkg for the distance width.
`default_nettype none

interface ped_dist_if;
  logic                        valid;
  logic                        ready;
  logic [ped_pkg::DIST_W-1:0]  distance;

  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface

`default_nettype wire

// ===== hdl/ped_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on ped_pkg for the index and data widths.
`default_nettype none

interface ped_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ped_pkg::CFG_IDX_W-1:0]   index;
  logic [ped_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ped_front.sv =====
// Front pipeline: differences, minimum-image pick, squares and sum of squares.
// Depends on ped_pkg, ped_pts_if and the assertion macro header.
`default_nettype none
`include "periodic_euclidean_distance_macros.svh"

module ped_front (
  input  logic                        clk,
  input  logic                        rst,
  input  ped_pkg::cfg_t               cfg,
  ped_pts_if.sink                     points,
  output logic                        sum_valid,
  input  logic                        sum_ready,
  output logic [ped_pkg::SUM_W-1:0]   sum
);

  function automatic logic [ped_pkg::MAG_W-1:0] abs_mag(
    input logic signed [ped_pkg::SGN_W-1:0] x
  );
    logic signed [ped_pkg::SGN_W-1:0] n;
    n = x[ped_pkg::SGN_W-1] ? -x : x;
    return n[ped_pkg::MAG_W-1:0];
  endfunction

  logic [ped_pkg::FRONT_STAGES-1:0] v;
  logic [ped_pkg::FRONT_STAGES-1:0] load;

  logic signed [ped_pkg::COORD_WIDTH-1:0] a_in [ped_pkg::FIELD_DIMS];
  logic signed [ped_pkg::COORD_WIDTH-1:0] b_in [ped_pkg::FIELD_DIMS];
  logic [ped_pkg::NUM_DIMS_W-1:0]         dims_eff;

  // stage A: differences
  logic signed [ped_pkg::DIFF_W-1:0]  diff_next [ped_pkg::FIELD_DIMS];
  logic [ped_pkg::FIELD_DIMS-1:0]     mask_next;
  logic signed [ped_pkg::DIFF_W-1:0]  diff_a [ped_pkg::FIELD_DIMS];
  logic [ped_pkg::FIELD_DIMS-1:0]     mask_a;
  logic                               mode_a;

  // stage B: magnitudes of the three candidates
  logic [ped_pkg::MAG_W-1:0]  mag0_next [ped_pkg::FIELD_DIMS];
  logic [ped_pkg::MAG_W-1:0]  magup_next [ped_pkg::FIELD_DIMS];
  logic [ped_pkg::MAG_W-1:0]  magdn_next [ped_pkg::FIELD_DIMS];
  logic [ped_pkg::MAG_W-1:0]  mag0_b [ped_pkg::FIELD_DIMS];
  logic [ped_pkg::MAG_W-1:0]  magup_b [ped_pkg::FIELD_DIMS];
  logic [ped_pkg::MAG_W-1:0]  magdn_b [ped_pkg::FIELD_DIMS];
  logic [ped_pkg::FIELD_DIMS-1:0] mask_b;
  logic                           mode_b;

  // stage C: smallest magnitude
  logic [ped_pkg::MAG_W-1:0]  min_next [ped_pkg::FIELD_DIMS];
  logic [ped_pkg::MAG_W-1:0]  min_c [ped_pkg::FIELD_DIMS];

  // stage D: squares
  logic [ped_pkg::SQ_W-1:0]   sq_next [ped_pkg::FIELD_DIMS];
  logic [ped_pkg::SQ_W-1:0]   sq_d [ped_pkg::FIELD_DIMS];

  // stages E and F: adder tree
  logic [ped_pkg::SUM_W-1:0]  pair_next [ped_pkg::FIELD_DIMS/2];
  logic [ped_pkg::SUM_W-1:0]  pair_e [ped_pkg::FIELD_DIMS/2];
  logic [ped_pkg::SUM_W-1:0]  sum_f;

  // A stage takes a new item when it is empty or its item moves on.
  always_comb begin
    load[ped_pkg::FRONT_STAGES-1] = !v[ped_pkg::FRONT_STAGES-1] || sum_ready;
    for (int s = ped_pkg::FRONT_STAGES - 2; s >= 0; s--) begin
      load[s] = !v[s] || load[s+1];
    end
  end

  // Hold the input off during reset: nothing enters until the stages are clear.
  assign points.ready = load[0] && !rst;
  assign sum_valid    = v[ped_pkg::FRONT_STAGES-1];
  assign sum          = sum_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[0]) begin
        v[0] <= points.valid;
      end
      for (int s = 1; s < ped_pkg::FRONT_STAGES; s++) begin
        if (load[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  always_comb begin
    a_in[0] = points.first_x0;
    a_in[1] = points.first_x1;
    a_in[2] = points.first_x2;
    a_in[3] = points.first_x3;
    b_in[0] = points.second_x0;
    b_in[1] = points.second_x1;
    b_in[2] = points.second_x2;
    b_in[3] = points.second_x3;
    if (cfg.num_dims > ped_pkg::NUM_DIMS_W'(ped_pkg::LIM_DIMS)) begin
      dims_eff = ped_pkg::NUM_DIMS_W'(ped_pkg::LIM_DIMS);
    end else begin
      dims_eff = cfg.num_dims;
    end
    for (int d = 0; d < ped_pkg::FIELD_DIMS; d++) begin
      diff_next[d] = ped_pkg::DIFF_W'(a_in[d]) - ped_pkg::DIFF_W'(b_in[d]);
      mask_next[d] = ped_pkg::NUM_DIMS_W'(d) < dims_eff;
    end
  end

  always_comb begin
    for (int d = 0; d < ped_pkg::FIELD_DIMS; d++) begin
      mag0_next[d]  = abs_mag(ped_pkg::SGN_W'(diff_a[d]));
      magup_next[d] = abs_mag(ped_pkg::SGN_W'(diff_a[d])
                              + ped_pkg::SGN_W'(signed'({1'b0, cfg.box_len[d]})));
      magdn_next[d] = abs_mag(ped_pkg::SGN_W'(diff_a[d])
                              - ped_pkg::SGN_W'(signed'({1'b0, cfg.box_len[d]})));
    end
  end

  // Smallest square comes from the smallest magnitude; drop unused dims.
  always_comb begin
    for (int d = 0; d < ped_pkg::FIELD_DIMS; d++) begin
      min_next[d] = mag0_b[d];
      if (mode_b) begin
        if (magup_b[d] < min_next[d]) begin
          min_next[d] = magup_b[d];
        end
        if (magdn_b[d] < min_next[d]) begin
          min_next[d] = magdn_b[d];
        end
      end
      if (!mask_b[d]) begin
        min_next[d] = '0;
      end
    end
  end

  always_comb begin
    for (int d = 0; d < ped_pkg::FIELD_DIMS; d++) begin
      sq_next[d] = ped_pkg::SQ_W'(min_c[d]) * ped_pkg::SQ_W'(min_c[d]);
    end
    for (int p = 0; p < ped_pkg::FIELD_DIMS / 2; p++) begin
      pair_next[p] = ped_pkg::SUM_W'(sq_d[2*p]) + ped_pkg::SUM_W'(sq_d[2*p+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      diff_a <= diff_next;
      mask_a <= mask_next;
      mode_a <= cfg.metric_mode;
    end
    if (load[1]) begin
      mag0_b  <= mag0_next;
      magup_b <= magup_next;
      magdn_b <= magdn_next;
      mask_b  <= mask_a;
      mode_b  <= mode_a;
    end
    if (load[2]) begin
      min_c <= min_next;
    end
    if (load[3]) begin
      sq_d <= sq_next;
    end
    if (load[4]) begin
      pair_e <= pair_next;
    end
    if (load[5]) begin
      sum_f <= pair_e[0] + pair_e[1];
    end
  end

  `PED_ASSERT_NXT(a_front_stall_hold,
                  v[ped_pkg::FRONT_STAGES-1] && !sum_ready,
                  v[ped_pkg::FRONT_STAGES-1] && $stable(sum_f),
                  "front: stalled sum changed or vanished")
  `PED_ASSERT_IMP(a_front_full_when_blocked,
                  !points.ready,
                  &v,
                  "front: input blocked while a stage is empty")
  `PED_ASSERT_NXT(a_front_no_phantom,
                  !v[ped_pkg::FRONT_STAGES-2] && load[ped_pkg::FRONT_STAGES-1],
                  !sum_valid,
                  "front: sum valid without an item behind it")

endmodule

`default_nettype wire

// ===== hdl/ped_sqrt.sv =====
// Pipelined restoring integer square root, one result bit per stage, with output clamp.
// Depends on ped_pkg, ped_dist_if and the assertion macro header.
`default_nettype none
`include "periodic_euclidean_distance_macros.svh"

module ped_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sum_valid,
  output logic                        sum_ready,
  input  logic [ped_pkg::SUM_W-1:0]   sum,
  ped_dist_if.source                  result
);

  logic [ped_pkg::ROOT_W-1:0] v_q;
  logic [ped_pkg::ROOT_W-1:0] load;

  logic [ped_pkg::RAD_W-1:0]  rad_q  [ped_pkg::ROOT_W];
  logic [ped_pkg::REM_W-1:0]  rem_q  [ped_pkg::ROOT_W];
  logic [ped_pkg::ROOT_W-1:0] root_q [ped_pkg::ROOT_W];

  logic [ped_pkg::RAD_W-1:0]  rad_next  [ped_pkg::ROOT_W];
  logic [ped_pkg::REM_W-1:0]  rem_next  [ped_pkg::ROOT_W];
  logic [ped_pkg::ROOT_W-1:0] root_next [ped_pkg::ROOT_W];

  logic [ped_pkg::RAD_W-1:0]  src_rad;
  logic [ped_pkg::REM_W-1:0]  src_rem;
  logic [ped_pkg::ROOT_W-1:0] src_root;
  logic [ped_pkg::REM_W-1:0]  rem_sh;
  logic [ped_pkg::REM_W-1:0]  trial;
  logic                       ge;

  logic [ped_pkg::CMP_W-1:0]  root_w;
  logic [ped_pkg::REM_W-1:0]  root_dbl;

  always_comb begin
    load[ped_pkg::ROOT_W-1] = !v_q[ped_pkg::ROOT_W-1] || result.ready;
    for (int s = ped_pkg::ROOT_W - 2; s >= 0; s--) begin
      load[s] = !v_q[s] || load[s+1];
    end
  end

  assign sum_ready = load[0];

  // Each stage brings down two radicand bits and decides one root bit.
  always_comb begin
    src_rad  = '0;
    src_rem  = '0;
    src_root = '0;
    rem_sh   = '0;
    trial    = '0;
    ge       = 1'b0;
    for (int s = 0; s < ped_pkg::ROOT_W; s++) begin
      if (s == 0) begin
        src_rad  = ped_pkg::RAD_W'(sum);
        src_rem  = '0;
        src_root = '0;
      end else begin
        src_rad  = rad_q[s-1];
        src_rem  = rem_q[s-1];
        src_root = root_q[s-1];
      end
      rem_sh = {src_rem[ped_pkg::REM_W-3:0], src_rad[ped_pkg::RAD_W-1 -: 2]};
      trial  = ped_pkg::REM_W'({src_root, 2'b01});
      ge     = rem_sh >= trial;
      rad_next[s]  = src_rad << 2;
      rem_next[s]  = ge ? (rem_sh - trial) : rem_sh;
      root_next[s] = {src_root[ped_pkg::ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else begin
      if (load[0]) begin
        v_q[0] <= sum_valid;
      end
      for (int s = 1; s < ped_pkg::ROOT_W; s++) begin
        if (load[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ped_pkg::ROOT_W; s++) begin
      if (load[s]) begin
        rad_q[s]  <= rad_next[s];
        rem_q[s]  <= rem_next[s];
        root_q[s] <= root_next[s];
      end
    end
  end

  // Clamp to the output range.
  always_comb begin
    root_w = ped_pkg::CMP_W'(root_q[ped_pkg::ROOT_W-1]);
    if (root_w > ped_pkg::CMP_W'(ped_pkg::DIST_MAX)) begin
      result.distance = ped_pkg::DIST_MAX;
    end else begin
      result.distance = ped_pkg::DIST_W'(root_w);
    end
  end

  assign result.valid = v_q[ped_pkg::ROOT_W-1];
  assign root_dbl     = ped_pkg::REM_W'({root_q[ped_pkg::ROOT_W-1], 1'b0});

  `PED_ASSERT_IMP(a_sqrt_rem_bound, v_q[ped_pkg::ROOT_W-1], rem_q[ped_pkg::ROOT_W-1] <= root_dbl, "sqrt: remainder exceeds twice the root")
  `PED_ASSERT_IMP(a_sqrt_first_bit, v_q[0], root_q[0] <= ped_pkg::ROOT_W'(1), "sqrt: first stage root wider than one bit")
  `PED_ASSERT_IMP(a_sqrt_full_when_blocked, !sum_ready, &v_q, "sqrt: input blocked while a stage is empty")

endmodule

`default_nettype wire

// ===== hdl/periodic_euclidean_distance.sv =====
// Top level of the periodic Euclidean distance block: config registers and the two pipelines.
// Depends on ped_pkg, the three channel interfaces, ped_front and ped_sqrt.
//
// Usage:
//   points : one item is a pair of points, four signed coordinates each. Only the first
//            num_dims dimensions count (num_dims above four acts as four).
//   result : one item per input item, in order: floor(sqrt(sum of squared differences)).
//            In periodic mode each dimension uses the smallest of the squared differences
//            with the second coordinate as is, shifted down or shifted up by its box length.
//   cfg    : register writes (0 metric_mode, 1 num_dims, 2..5 box lengths), ready outside
//            reset. Write only while no item is in flight; indexes past the list are ignored.
// Throughput: one item per cycle while result.ready is high. An accepted item passes
//   through the difference/square/sum pipeline and then the square root pipeline, one root
//   bit per stage.
// Stall: when result.ready is low the last stage holds its item; earlier stages keep
//   filling bubbles, and points.ready drops only once every stage holds an item.
// Reset: empties all stages and holds points.ready and cfg.ready low; metric_mode 0,
//   num_dims 3, box lengths 0.
`default_nettype none

module periodic_euclidean_distance (
  input  logic        clk,
  input  logic        rst,
  ped_cfg_if.sink     cfg,
  ped_pts_if.sink     points,
  ped_dist_if.source  result
);

  ped_pkg::cfg_t               cfg_r;
  logic                        sum_valid;
  logic                        sum_ready;
  logic [ped_pkg::SUM_W-1:0]   sum;

  // Take writes whenever out of reset.
  assign cfg.ready = !rst;

  // Register file; write only while the pipelines are idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r.metric_mode <= 1'b0;
      cfg_r.num_dims    <= ped_pkg::NUM_DIMS_RST;
      cfg_r.box_len     <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        ped_pkg::REG_METRIC_MODE: cfg_r.metric_mode <= cfg.data[0];
        ped_pkg::REG_NUM_DIMS:    cfg_r.num_dims <= cfg.data[ped_pkg::NUM_DIMS_W-1:0];
        ped_pkg::REG_BOX_LEN_0:   cfg_r.box_len[0] <= cfg.data[ped_pkg::BOX_W-1:0];
        ped_pkg::REG_BOX_LEN_1:   cfg_r.box_len[1] <= cfg.data[ped_pkg::BOX_W-1:0];
        ped_pkg::REG_BOX_LEN_2:   cfg_r.box_len[2] <= cfg.data[ped_pkg::BOX_W-1:0];
        ped_pkg::REG_BOX_LEN_3:   cfg_r.box_len[3] <= cfg.data[ped_pkg::BOX_W-1:0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  // Differences, minimum-image pick, squares and their sum.
  ped_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_r),
    .points    (points),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum)
  );

  // Square root and output clamp; its last stage is the output register.
  ped_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .result    (result)
  );

endmodule

`default_nettype wire
